FILE: rtl/gpg_pkg.sv
// Gabor patch pixel generator: shared constants, lookup tables and trig helpers.
// No dependencies; used by gabor_patch_pixel_generator_unit.
package gpg_pkg;

    localparam int ORIENTS_DEF  = 16;
    localparam int PHASES_DEF   = 16;
    localparam int MAX_SIZE_DEF = 256;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SPATIAL_FREQ = 2'd0;
    localparam logic [1:0] REG_INV_TWO_SIG  = 2'd1;
    localparam logic [1:0] REG_PATCH_SIZE   = 2'd2;

    localparam logic [15:0] SPATIAL_FREQ_RST = 16'd4096;
    localparam logic [15:0] INV_TWO_SIG_RST  = 16'd256;
    localparam logic [8:0]  PATCH_SIZE_RST   = 9'd64;

    // Gaussian argument limit in Q8 (12.0)
    localparam logic [28:0] XQ_LIMIT = 29'd3072;

    typedef logic signed [16:0] trig_t;

    localparam logic [15:0] QUARTER_SINE [33] = '{
        16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,  16'd11039,
        16'd12539, 16'd14010, 16'd15446, 16'd16846, 16'd18204, 16'd19519, 16'd20787, 16'd22005,
        16'd23170, 16'd24279, 16'd25330, 16'd26319, 16'd27245, 16'd28105, 16'd28898, 16'd29621,
        16'd30273, 16'd30852, 16'd31356, 16'd31785, 16'd32137, 16'd32412, 16'd32609, 16'd32728,
        16'd32767
    };

    localparam logic [15:0] EXP_WHOLE [12] = '{
        16'd32768, 16'd12055, 16'd4435, 16'd1631, 16'd600, 16'd221,
        16'd81,    16'd30,    16'd11,   16'd4,    16'd1,   16'd1
    };

    localparam logic [15:0] EXP_FRAC [17] = '{
        16'd32768, 16'd30783, 16'd28918, 16'd27166, 16'd25520, 16'd23974, 16'd22521, 16'd21157,
        16'd19875, 16'd18671, 16'd17540, 16'd16477, 16'd15479, 16'd14541, 16'd13660, 16'd12832,
        16'd12055
    };

    // Sine of a 16-bit turn fraction, Q1.15, table with rounded linear interpolation
    function automatic trig_t sin_turn(input logic [15:0] p);
        logic [14:0] r;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [15:0] d;
        logic [24:0] prod;
        logic [15:0] v;
        r    = {1'b0, p[13:0]};
        if (p[14])
        begin
            r = 15'd16384 - r;
        end
        idx  = r[14:9];
        frac = r[8:0];
        if (idx[5])
        begin
            v = QUARTER_SINE[32];
        end
        else
        begin
            d    = QUARTER_SINE[idx + 6'd1] - QUARTER_SINE[idx];
            prod = 25'(d) * 25'(frac) + 25'd256;
            v    = QUARTER_SINE[idx] + prod[24:9];
        end
        sin_turn = p[15] ? -trig_t'({1'b0, v}) : trig_t'({1'b0, v});
    endfunction

    function automatic trig_t cos_turn(input logic [15:0] p);
        cos_turn = sin_turn(p + 16'd16384);
    endfunction

endpackage

FILE: rtl/gabor_patch_pixel_generator_unit.sv
// Gabor patch pixel generator, top level: ten-stage pipeline, one pixel per item.
// Depends on gpg_pkg (tables, sin_turn/cos_turn, register indexes).
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | s_tdata: orient_index, phase_index, col, row
//  m_*       | out | m_tvalid/m_tready  | m_tdata: pixel_value (signed Q1.15)
//  cfg_*     | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
// One transfer in per cycle, one pixel out per cycle while m_tready is high; the
// ten register stages are trig lookup, rotation products, sums, frequency
// product, squares, cosine, Gaussian product, exp fraction, exp product, final
// scaling. Each stage holds its own valid bit and advances when its successor
// is empty or moving, so bubbles close up under a stall.
// Reset empties the pipeline and loads the register reset values.
module gabor_patch_pixel_generator_unit
    import gpg_pkg::*;
#(
    parameter int ORIENTS  = ORIENTS_DEF,
    parameter int PHASES   = PHASES_DEF,
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] orient_index, [7:4] phase_index, [15:8] col, [23:16] row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pixel_value
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NST = 10;

    // Configuration registers
    logic [15:0] freq_reg;
    logic [15:0] isq_reg;
    logic [8:0]  size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= SPATIAL_FREQ_RST;
            isq_reg  <= INV_TWO_SIG_RST;
            size_reg <= PATCH_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPATIAL_FREQ: freq_reg <= cfg_data;
                REG_INV_TWO_SIG:  isq_reg  <= cfg_data;
                REG_PATCH_SIZE:   size_reg <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // Valid bits and per-stage advance; stage i sits at bit i-1
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];

    // Stage 1: unpack, clamp size, center coordinates, orientation trig
    logic [3:0]  in_orient;
    logic [3:0]  in_phase;
    logic [7:0]  in_col;
    logic [7:0]  in_row;
    logic [8:0]  size_eff;
    logic [15:0] angle_lut [16];
    logic [15:0] poff_lut [16];

    assign in_orient = s_tdata[3:0];
    assign in_phase  = s_tdata[7:4];
    assign in_col    = s_tdata[15:8];
    assign in_row    = s_tdata[23:16];

    // Orientation angle and phase offset per index, as turn fractions
    for (genvar k = 0; k < 16; k++)
    begin : g_turn_lut
        assign angle_lut[k] = 16'((k * 32768) / ORIENTS);
        assign poff_lut[k]  = 16'((k * 65536) / PHASES);
    end

    always_comb
    begin
        size_eff = size_reg;
        if (size_reg == 9'd0)
        begin
            size_eff = 9'd1;
        end
        else if (32'(size_reg) > 32'(MAX_SIZE))
        begin
            size_eff = 9'(MAX_SIZE);
        end
    end

    trig_t              c1_reg, s1_reg;
    logic signed [10:0] hx1_reg, hy1_reg;
    logic [15:0]        poff1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            c1_reg    <= cos_turn(angle_lut[in_orient]);
            s1_reg    <= sin_turn(angle_lut[in_orient]);
            hx1_reg   <= $signed({2'b00, in_col, 1'b0}) - $signed({2'b00, size_eff}) + 11'sd1;
            hy1_reg   <= $signed({2'b00, in_row, 1'b0}) - $signed({2'b00, size_eff}) + 11'sd1;
            poff1_reg <= poff_lut[in_phase];
        end
    end

    // Stage 2: rotation products
    logic signed [27:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic [15:0]        poff2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            p1_reg    <= 28'(c1_reg) * 28'(hx1_reg);
            p2_reg    <= 28'(s1_reg) * 28'(hy1_reg);
            p3_reg    <= 28'(s1_reg) * 28'(hx1_reg);
            p4_reg    <= 28'(c1_reg) * 28'(hy1_reg);
            poff2_reg <= poff1_reg;
        end
    end

    // Stage 3: rotated coordinates, times 65536
    logic signed [28:0] dxq3_reg, dyq3_reg;
    logic [15:0]        poff3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            dxq3_reg  <= 29'(p1_reg) - 29'(p2_reg);
            dyq3_reg  <= 29'(p3_reg) + 29'(p4_reg);
            poff3_reg <= poff2_reg;
        end
    end

    // Stage 4: frequency product, Q8 magnitudes
    logic [28:0] adx, ady, adx_r, ady_r;

    always_comb
    begin
        adx   = dxq3_reg[28] ? 29'(-dxq3_reg) : 29'(dxq3_reg);
        ady   = dyq3_reg[28] ? 29'(-dyq3_reg) : 29'(dyq3_reg);
        adx_r = adx + 29'd128;
        ady_r = ady + 29'd128;
    end

    logic signed [45:0] fp4_reg;
    logic [16:0]        dx8_4_reg, dy8_4_reg;
    logic [15:0]        poff4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            fp4_reg   <= $signed({30'd0, freq_reg}) * 46'(dxq3_reg);
            dx8_4_reg <= adx_r[24:8];
            dy8_4_reg <= ady_r[24:8];
            poff4_reg <= poff3_reg;
        end
    end

    // Stage 5: carrier phase, squared distances
    logic [31:0] fp_round;
    assign fp_round = fp4_reg[31:0] + 32'd32768;

    logic [15:0] phase5_reg;
    logic [33:0] sx5_reg, sy5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            phase5_reg <= fp_round[31:16] + poff4_reg;
            sx5_reg    <= 34'(dx8_4_reg) * 34'(dx8_4_reg);
            sy5_reg    <= 34'(dy8_4_reg) * 34'(dy8_4_reg);
        end
    end

    // Stage 6: carrier cosine, radius squared
    logic [34:0] r2_sum;
    assign r2_sum = 35'(sx5_reg) + 35'(sy5_reg);

    trig_t       cv6_reg;
    logic [31:0] r2lo6_reg;
    logic        big6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            cv6_reg   <= cos_turn(phase5_reg);
            r2lo6_reg <= r2_sum[31:0];
            big6_reg  <= r2_sum[34:32] != 3'd0;
        end
    end

    // Stage 7: Gaussian argument product
    logic [47:0] gp7_reg;
    logic        big7_reg;
    trig_t       cv7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            gp7_reg  <= 48'(r2lo6_reg) * 48'(isq_reg);
            big7_reg <= big6_reg && (isq_reg != 16'd0);
            cv7_reg  <= cv6_reg;
        end
    end

    // Stage 8: Q8 argument, range check, interpolated fractional exponential
    logic [48:0] xq_sum;
    logic [28:0] xq;
    logic [3:0]  xk, xfr;
    logic [15:0] fdiff;
    logic [19:0] fstep;

    always_comb
    begin
        xq_sum = 49'(gp7_reg) + 49'd524288;
        xq     = xq_sum[48:20];
        xk     = xq[7:4];
        xfr    = xq[3:0];
        fdiff  = EXP_FRAC[5'(xk)] - EXP_FRAC[5'(xk) + 5'd1];
        fstep  = 20'(fdiff) * 20'(xfr) + 20'd8;
    end

    logic        zero8_reg;
    logic [3:0]  n8_reg;
    logic [15:0] b8_reg;
    trig_t       cv8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            zero8_reg <= big7_reg || (xq >= XQ_LIMIT);
            n8_reg    <= xq[11:8];
            b8_reg    <= EXP_FRAC[5'(xk)] - fstep[19:4];
            cv8_reg   <= cv7_reg;
        end
    end

    // Stage 9: Gaussian factor, Q15
    logic [31:0] gprod;
    logic [15:0] ewhole;

    always_comb
    begin
        ewhole = (n8_reg < 4'd12) ? EXP_WHOLE[n8_reg] : 16'd0;
        gprod  = 32'(ewhole) * 32'(b8_reg) + 32'd16384;
    end

    logic [15:0] g9_reg;
    trig_t       cv9_reg;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            g9_reg  <= zero8_reg ? 16'd0 : gprod[30:15];
            cv9_reg <= cv8_reg;
        end
    end

    // Stage 10: scale magnitude, restore sign
    logic [15:0] mag;
    logic [31:0] rprod;
    logic [15:0] res;

    always_comb
    begin
        mag   = cv9_reg[16] ? 16'(-cv9_reg) : 16'(cv9_reg);
        rprod = 32'(mag) * 32'(g9_reg) + 32'd16384;
        res   = rprod[30:15];
        if (cv9_reg[16])
        begin
            res = 16'd0 - res;
        end
    end

    logic [15:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = out_reg;

    // An empty output stage must never block the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NST-1] |-> s_tready)
        else $error("input stalled while output stage empty");

    // Gaussian factor never exceeds 1.0
    a_gauss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[8] |-> (g9_reg <= 16'd32768))
        else $error("gaussian factor above one");

    // Zero width register gives unit Gaussian
    a_gauss_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[8] && isq_reg == 16'd0) |-> (g9_reg == 16'd32768))
        else $error("gaussian not unity with zero width register");

    // Pixel stays within -32767..32767
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata != 16'h8000))
        else $error("pixel out of range");

endmodule
